/* rtl/core/qbce_pkg.sv */
// ----------------------------------------------------------------------------
// qbce_pkg
// Shared constants, types and the character table for the quadrant block
// character encoder.
// ----------------------------------------------------------------------------
package qbce_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int SLOT_COUNT   = (MAX_WIDTH + 1) / 2;
    localparam int SLOT_W       = $clog2(SLOT_COUNT);
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
    localparam int WIDTH_CFG_W  = 11;
    localparam int HEIGHT_CFG_W = 13;
    localparam int PIX_W        = 8;
    localparam int CODE_W       = 8;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int PAIR_W       = 2;

    localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = WIDTH_CFG_W'(1024);
    localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = HEIGHT_CFG_W'(1024);

    typedef enum logic
    {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic [3:0] idx_part;
        logic       use_top;
        logic       row_end;
        logic       frame_end;
    } cell_stage_t;

    function automatic logic [CODE_W-1:0] code_lookup(input logic [3:0] idx);
        logic [CODE_W-1:0] code;
        unique case (idx)
            4'd0:    code = 8'd32;
            4'd1:    code = 8'd124;
            4'd2:    code = 8'd108;
            4'd3:    code = 8'd225;
            4'd4:    code = 8'd123;
            4'd5:    code = 8'd255;
            4'd6:    code = 8'd98;
            4'd7:    code = 8'd254;
            4'd8:    code = 8'd126;
            4'd9:    code = 8'd226;
            4'd10:   code = 8'd127;
            4'd11:   code = 8'd251;
            4'd12:   code = 8'd97;
            4'd13:   code = 8'd236;
            4'd14:   code = 8'd252;
            default: code = 8'd224;
        endcase
        return code;
    endfunction

endpackage

/* rtl/core/qbce_line_ram.sv */
// ----------------------------------------------------------------------------
// qbce_line_ram
// Simple dual-port line buffer: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module qbce_line_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 2,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/quadrant_block_char_encoder.sv */
// ----------------------------------------------------------------------------
// quadrant_block_char_encoder
// Turns raster RGB pixels into 2x2 quadrant block character codes, one code
// per cell, with row-end and frame-end marks.
//
//   channel   direction  handshake                     payload
//   pixel     in         pixel_valid / pixel_stall     red, green, blue
//   char      out        char_valid / char_stall       char_code, row_end, frame_end
//   config    in         APB (psel, penable, pready)   image_width, image_height
//
// One pixel per cycle is accepted while pixel_stall is low; the cell stage and the
// line buffer read port register a finished cell, the output register its code.
// rst_n clears counters, pipeline valids and loads the register defaults;
// the line buffer is not cleared. A stall on char holds the output register
// and the cell stage; pixel_stall rises only while both are full.
// A register write restarts the frame.
// ----------------------------------------------------------------------------
module quadrant_block_char_encoder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qbce_pkg::PADDR_W-1:0]   paddr,
    input  logic [qbce_pkg::PDATA_W-1:0]   pwdata,
    output logic [qbce_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    input  logic                           pixel_valid,
    output logic                           pixel_stall,
    input  logic [qbce_pkg::PIX_W-1:0]     red,
    input  logic [qbce_pkg::PIX_W-1:0]     green,
    input  logic [qbce_pkg::PIX_W-1:0]     blue,
    output logic                           char_valid,
    input  logic                           char_stall,
    output logic [qbce_pkg::CODE_W-1:0]    char_code,
    output logic                           row_end,
    output logic                           frame_end
);

    import qbce_pkg::*;

    logic [WIDTH_CFG_W-1:0]  width_reg;
    logic [HEIGHT_CFG_W-1:0] height_reg;
    logic [COL_W-1:0]        col_reg, col_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic                    left_reg, left_next;
    logic                    cell_valid_reg, cell_valid_next;
    cell_stage_t             cell_reg, cell_next;
    logic                    out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]       code_reg;
    logic                    row_end_reg, frame_end_reg;

    logic                    cfg_write;
    reg_index_t              cfg_sel;
    logic [COL_W-1:0]        col_lim;
    logic [ROW_W-1:0]        row_lim;
    logic                    out_adv, pixel_accept;
    logic                    fg, even_row, odd_col, last_col, last_row, emit;
    logic [SLOT_W-1:0]       slot;
    logic                    buf_wr_en;
    logic [PAIR_W-1:0]       buf_wr_data, buf_rd_data;
    logic [3:0]              cell_idx;

    assign cfg_sel   = reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        unique case (cfg_sel)
            REG_IMAGE_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = PDATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb
    begin
        priority if (width_reg == '0)
            col_lim = '0;
        else if (width_reg > WIDTH_CFG_W'(MAX_WIDTH))
            col_lim = COL_W'(MAX_WIDTH - 1);
        else
            col_lim = COL_W'(width_reg - 1'b1);

        priority if (height_reg == '0)
            row_lim = '0;
        else if (height_reg > HEIGHT_CFG_W'(HEIGHT_LIMIT))
            row_lim = ROW_W'(HEIGHT_LIMIT - 1);
        else
            row_lim = ROW_W'(height_reg - 1'b1);
    end

    assign out_adv      = !out_valid_reg || !char_stall;
    assign pixel_stall  = cell_valid_reg && !out_adv;
    assign pixel_accept = pixel_valid && !pixel_stall;

    assign fg       = (red | green | blue) != '0;
    assign even_row = !row_reg[0];
    assign odd_col  = col_reg[0];
    assign last_col = col_reg >= col_lim;
    assign last_row = row_reg >= row_lim;
    assign emit     = (odd_col || last_col) && (!even_row || last_row);
    assign slot     = col_reg[COL_W-1:1];

    assign buf_wr_en   = pixel_accept && !cfg_write && even_row && !last_row
                         && (odd_col || last_col);
    assign buf_wr_data = odd_col ? {left_reg, fg} : {fg, 1'b0};

    qbce_line_ram #(
        .DEPTH (SLOT_COUNT),
        .WIDTH (PAIR_W)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (buf_wr_en),
        .wr_addr (slot),
        .wr_data (buf_wr_data),
        .rd_en   (pixel_accept),
        .rd_addr (slot),
        .rd_data (buf_rd_data)
    );

    always_comb
    begin
        logic first_bit;
        logic second_bit;
        first_bit  = odd_col ? left_reg : fg;
        second_bit = odd_col && fg;

        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        if (cfg_write)
        begin
            col_next  = '0;
            row_next  = '0;
            left_next = 1'b0;
        end
        else if (pixel_accept)
        begin
            if (!odd_col)
            begin
                left_next = fg;
            end
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end

        cell_next.use_top   = !even_row;
        cell_next.row_end   = last_col;
        cell_next.frame_end = last_col && last_row;
        if (even_row)
            cell_next.idx_part = {first_bit, 2'b00, second_bit};
        else
            cell_next.idx_part = {1'b0, first_bit, second_bit, 1'b0};

        cell_valid_next = cell_valid_reg;
        if (pixel_accept && !cfg_write)
            cell_valid_next = emit;
        else if (out_adv)
            cell_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_adv)
            out_valid_next = cell_valid_reg;
    end

    assign cell_idx = cell_reg.idx_part
                      | (cell_reg.use_top ? {buf_rd_data[1], 2'b00, buf_rd_data[0]} : 4'b0000);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= WIDTH_RESET;
            height_reg     <= HEIGHT_RESET;
            col_reg        <= '0;
            row_reg        <= '0;
            left_reg       <= 1'b0;
            cell_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_sel)
                    REG_IMAGE_WIDTH:  width_reg  <= pwdata[WIDTH_CFG_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg <= pwdata[HEIGHT_CFG_W-1:0];
                    default:          width_reg  <= width_reg;
                endcase
            end
            col_reg        <= col_next;
            row_reg        <= row_next;
            left_reg       <= left_next;
            cell_valid_reg <= cell_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            cell_reg <= cell_next;
        end
        if (out_adv && cell_valid_reg)
        begin
            code_reg      <= code_lookup(cell_idx);
            row_end_reg   <= cell_reg.row_end;
            frame_end_reg <= cell_reg.frame_end;
        end
    end

    assign char_valid = out_valid_reg;
    assign char_code  = code_reg;
    assign row_end    = row_end_reg;
    assign frame_end  = frame_end_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (cell_valid_reg && out_valid_reg))
        else $error("pixel stall raised with a free pipeline slot");

    a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!frame_end_reg || row_end_reg))
        else $error("frame end without row end");

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> (col_reg == '0 && row_reg == '0 && !left_reg))
        else $error("register write did not restart the frame");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= col_lim)
        else $error("column counter beyond row width");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= row_lim)
        else $error("row counter beyond frame height");

endmodule
